/* design/dtps_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtps_pkg
// Shared types, register codes and the window table builder of the pitch shifter.
// ----------------------------------------------------------------------------
package dtps_pkg;

    // Configuration register indexes.
    localparam logic [1:0] REG_OCTAVE     = 2'd0;
    localparam logic [1:0] REG_PHASE_STEP = 2'd1;
    localparam logic [1:0] REG_SWEEP_SPAN = 2'd2;

    localparam longint Q30_ONE     = 64'sd1073741824;
    localparam longint Q30_HALF_PI = 64'sd1686629713;

    // Configuration seen by the back end.
    typedef struct packed {
        logic signed [2:0] octave;
        logic [23:0]       phase_step;
        logic [23:0]       sweep_span;
    } dtps_cfg_t;

    // Back-end sequencer states.
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_READ0,
        ST_READ1,
        ST_TAP,
        ST_MAC,
        ST_OUT
    } dtps_state_t;

    // Cosine of entry k of a table of 2**tb entries, Q1.16, by a Taylor series
    // in Q30. Evaluated at elaboration only.
    function automatic logic signed [17:0] cos_entry(input int k, input int tb);
        longint t;
        longint q;
        longint r;
        longint x;
        longint arg;
        longint x2;
        longint h;
        longint c;
        t   = longint'(k) <<< (32 - tb);
        q   = (t >>> 30) & 64'sd3;
        r   = t & (Q30_ONE - 64'sd1);
        x   = (r * Q30_HALF_PI) >>> 30;
        arg = (q == 64'sd0 || q == 64'sd2) ? x : Q30_HALF_PI - x;
        x2  = (arg * arg) / Q30_ONE;
        h   = Q30_ONE;
        h   = Q30_ONE - ((x2 * h) / Q30_ONE) / 64'sd132;
        h   = Q30_ONE - ((x2 * h) / Q30_ONE) / 64'sd90;
        h   = Q30_ONE - ((x2 * h) / Q30_ONE) / 64'sd56;
        h   = Q30_ONE - ((x2 * h) / Q30_ONE) / 64'sd30;
        h   = Q30_ONE - ((x2 * h) / Q30_ONE) / 64'sd12;
        h   = Q30_ONE - ((x2 * h) / Q30_ONE) / 64'sd2;
        c   = (q == 64'sd1 || q == 64'sd2) ? -h : h;
        c   = (c + 64'sd8192) / 64'sd16384;
        if (c > 64'sd65536) c = 64'sd65536;
        if (c < -64'sd65536) c = -64'sd65536;
        return c[17:0];
    endfunction

    // Raised-cosine weight (1 - cos) / 2 in Q1.16.
    function automatic logic [16:0] window_weight(input int k, input int tb);
        logic signed [18:0] d;
        d = 19'sd65536 - 19'(cos_entry(k, tb));
        return d[17:1];
    endfunction

endpackage

/* design/dtps_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtps_front
// Configuration registers, input acceptance and a two-entry request queue.
// ----------------------------------------------------------------------------
module dtps_front #(
    parameter int DELAY_DEPTH = 65536,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_addr,
    input  logic [23:0]                cfg_wdata,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [2*SAMPLE_BITS-1:0]   s_data,
    input  logic                       clearing,
    output logic                       q_valid,
    input  logic                       q_ready,
    output logic [2*SAMPLE_BITS-1:0]   q_data,
    output dtps_pkg::dtps_cfg_t        cfg
);

    localparam logic [63:0] SPAN_CAP = 64'(DELAY_DEPTH - 2) * 64'd256;

    dtps_pkg::dtps_cfg_t cfg_reg, cfg_next;
    logic [2*SAMPLE_BITS-1:0] q_mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    // Register writes; the span saturates at the store length minus two.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                dtps_pkg::REG_OCTAVE:     cfg_next.octave = cfg_wdata[2:0];
                dtps_pkg::REG_PHASE_STEP: cfg_next.phase_step = cfg_wdata;
                dtps_pkg::REG_SWEEP_SPAN: begin
                    if (64'(cfg_wdata) > SPAN_CAP) begin
                        cfg_next.sweep_span = SPAN_CAP[23:0];
                    end else begin
                        cfg_next.sweep_span = cfg_wdata;
                    end
                end
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.octave     <= 3'sd0;
            cfg_reg.phase_step <= 24'd2796;
            cfg_reg.sweep_span <= 24'd0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

    // Request queue.
    assign s_ready    = (count_reg != 2'd2) && !clearing;
    assign push       = s_valid && s_ready;
    assign q_valid    = (count_reg != 2'd0);
    assign pop        = q_valid && q_ready;
    assign q_data     = q_mem_reg[rd_ptr_reg];
    assign count_next = count_reg + {1'b0, push} - {1'b0, pop};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop) rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) q_mem_reg[wr_ptr_reg] <= s_data;
    end

endmodule

/* design/dtps_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtps_back
// Delay stores, tap sequencer, interpolation, windowing and output register.
// ----------------------------------------------------------------------------
module dtps_back #(
    parameter int DELAY_DEPTH       = 65536,
    parameter int SAMPLE_BITS       = 24,
    parameter int WINDOW_TABLE_SIZE = 1024
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  dtps_pkg::dtps_cfg_t        cfg,
    input  logic                       q_valid,
    output logic                       q_ready,
    input  logic [2*SAMPLE_BITS-1:0]   q_data,
    output logic                       clearing,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [2*SAMPLE_BITS-1:0]   m_data
);

    localparam int SB  = SAMPLE_BITS;
    localparam int AW  = $clog2(DELAY_DEPTH);
    localparam int TB  = $clog2(WINDOW_TABLE_SIZE);
    localparam int RW  = ((AW + 8 > 24) ? AW + 8 : 24) + 1;
    localparam int TW  = SB + 10;
    localparam int PW  = TW + 18;
    localparam int SW  = PW + 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(DELAY_DEPTH - 1);
    localparam logic signed [RW-1:0] WRAP = RW'(longint'(DELAY_DEPTH) * 256);

    dtps_pkg::dtps_state_t state_reg, state_next;

    logic [SB-1:0] mem_l [DELAY_DEPTH];
    logic [SB-1:0] mem_r [DELAY_DEPTH];
    logic [SB-1:0] rd_l_reg, rd_r_reg;
    logic          mem_we;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [SB-1:0] wr_l, wr_r;

    logic [16:0] w_rom [WINDOW_TABLE_SIZE];

    logic [AW-1:0]  wp_reg;
    logic [23:0]    phase_reg;
    logic [SB-1:0]  in_l_reg, in_r_reg;
    logic           pass_reg;
    logic           tap_sel_reg;
    logic [36:0]    prod_reg;
    logic [23:0]    delay_reg;
    logic [AW-1:0]  i0_reg;
    logic [7:0]     frac_reg;
    logic [16:0]    w_reg;
    logic signed [SB-1:0] y0_l_reg, y0_r_reg;
    logic signed [TW-1:0] tap_l_reg, tap_r_reg;
    logic signed [SW-1:0] acc_l_reg, acc_r_reg;
    logic           m_valid_reg;
    logic [2*SB-1:0] m_data_reg;

    logic [23:0]    ph;
    logic           up;
    logic [24:0]    eff;
    logic [48:0]    delay_full;
    logic signed [RW-1:0] rp_raw, rp;
    logic [AW-1:0]  i0_c, i1_c;
    logic           out_free;
    logic signed [SW-1:0] acc_l_next, acc_r_next;

    // Floor shift by 24 and saturation to the sample width.
    function automatic logic [SB-1:0] sat(input logic signed [SW-1:0] a);
        logic signed [SW-25:0] s;
        s = a[SW-1:24];
        if (s > $signed((SW-24)'({1'b0, {(SB-1){1'b1}}}))) return {1'b0, {(SB-1){1'b1}}};
        if (s < -$signed((SW-24)'({1'b1, {(SB-1){1'b0}}}))) return {1'b1, {(SB-1){1'b0}}};
        return s[SB-1:0];
    endfunction

    // Window weight table, built at elaboration.
    for (genvar k = 0; k < WINDOW_TABLE_SIZE; k++) begin : g_win
        assign w_rom[k] = dtps_pkg::window_weight(k, TB);
    end

    // Tap phase, direction and effective phase.
    assign ph  = tap_sel_reg ? phase_reg + 24'h800000 : phase_reg;
    assign up  = !cfg.octave[2] && (cfg.octave != 3'sd0);
    assign eff = up ? 25'h1000000 - {1'b0, ph} : {1'b0, ph};

    // Second half of the delay product.
    assign delay_full = {12'd0, prod_reg}
                      + ({24'd0, eff} * {37'd0, cfg.sweep_span[23:12]} << 12);

    // Read position, wrapped once into the store.
    assign rp_raw = RW'({wp_reg, 8'd0}) - RW'(delay_reg);
    assign rp     = rp_raw[RW-1] ? rp_raw + WRAP : rp_raw;
    assign i0_c   = rp[AW+7:8];
    assign i1_c   = (i0_reg == LAST_ADDR) ? '0 : i0_reg + 1'b1;

    assign out_free = !m_valid_reg || m_ready;
    assign clearing = (state_reg == dtps_pkg::ST_CLEAR);
    assign q_ready  = (state_reg == dtps_pkg::ST_IDLE);

    // Multiply-accumulate of one weighted tap.
    assign acc_l_next = (tap_sel_reg ? acc_l_reg : '0)
                      + SW'(tap_l_reg * $signed({1'b0, w_reg}));
    assign acc_r_next = (tap_sel_reg ? acc_r_reg : '0)
                      + SW'(tap_r_reg * $signed({1'b0, w_reg}));

    // Memory port control.
    always_comb begin
        mem_we  = 1'b0;
        wr_addr = wp_reg;
        wr_l    = in_l_reg;
        wr_r    = in_r_reg;
        rd_addr = i1_c;
        if (state_reg == dtps_pkg::ST_CLEAR) begin
            mem_we = 1'b1;
            wr_l   = '0;
            wr_r   = '0;
        end else if (state_reg == dtps_pkg::ST_WRITE) begin
            mem_we = 1'b1;
        end
        if (state_reg == dtps_pkg::ST_READ0) rd_addr = i0_c;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem_l[wr_addr] <= wr_l;
            mem_r[wr_addr] <= wr_r;
        end
        rd_l_reg <= mem_l[rd_addr];
        rd_r_reg <= mem_r[rd_addr];
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            dtps_pkg::ST_CLEAR:  if (wp_reg == LAST_ADDR) state_next = dtps_pkg::ST_IDLE;
            dtps_pkg::ST_IDLE:   if (q_valid) state_next = dtps_pkg::ST_WRITE;
            dtps_pkg::ST_WRITE:  state_next = (cfg.octave == 3'sd0) ? dtps_pkg::ST_OUT
                                                                     : dtps_pkg::ST_MUL_LO;
            dtps_pkg::ST_MUL_LO: state_next = dtps_pkg::ST_MUL_HI;
            dtps_pkg::ST_MUL_HI: state_next = dtps_pkg::ST_READ0;
            dtps_pkg::ST_READ0:  state_next = dtps_pkg::ST_READ1;
            dtps_pkg::ST_READ1:  state_next = dtps_pkg::ST_TAP;
            dtps_pkg::ST_TAP:    state_next = dtps_pkg::ST_MAC;
            dtps_pkg::ST_MAC:    state_next = tap_sel_reg ? dtps_pkg::ST_OUT
                                                          : dtps_pkg::ST_MUL_LO;
            dtps_pkg::ST_OUT:    if (out_free) state_next = dtps_pkg::ST_IDLE;
            default:             state_next = dtps_pkg::ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= dtps_pkg::ST_CLEAR;
            wp_reg      <= '0;
            phase_reg   <= '0;
            tap_sel_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == dtps_pkg::ST_CLEAR) begin
                wp_reg <= (wp_reg == LAST_ADDR) ? '0 : wp_reg + 1'b1;
            end
            if (state_reg == dtps_pkg::ST_WRITE) tap_sel_reg <= 1'b0;
            if (state_reg == dtps_pkg::ST_MAC) tap_sel_reg <= 1'b1;
            if (state_reg == dtps_pkg::ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
                wp_reg      <= (wp_reg == LAST_ADDR) ? '0 : wp_reg + 1'b1;
                phase_reg   <= phase_reg + cfg.phase_step;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            dtps_pkg::ST_IDLE: begin
                in_l_reg <= q_data[SB-1:0];
                in_r_reg <= q_data[2*SB-1:SB];
            end
            dtps_pkg::ST_WRITE: pass_reg <= (cfg.octave == 3'sd0);
            dtps_pkg::ST_MUL_LO: begin
                prod_reg <= {12'd0, eff} * {25'd0, cfg.sweep_span[11:0]};
                w_reg    <= w_rom[ph[23 -: TB]];
            end
            dtps_pkg::ST_MUL_HI: delay_reg <= delay_full[47:24];
            dtps_pkg::ST_READ0: begin
                i0_reg   <= i0_c;
                frac_reg <= rp[7:0];
            end
            dtps_pkg::ST_READ1: begin
                y0_l_reg <= rd_l_reg;
                y0_r_reg <= rd_r_reg;
            end
            dtps_pkg::ST_TAP: begin
                tap_l_reg <= (TW'(y0_l_reg) <<< 8) + TW'($signed({1'b0, frac_reg})
                           * ($signed({rd_l_reg[SB-1], rd_l_reg}) - (SB+1)'(y0_l_reg)));
                tap_r_reg <= (TW'(y0_r_reg) <<< 8) + TW'($signed({1'b0, frac_reg})
                           * ($signed({rd_r_reg[SB-1], rd_r_reg}) - (SB+1)'(y0_r_reg)));
            end
            dtps_pkg::ST_MAC: begin
                acc_l_reg <= acc_l_next;
                acc_r_reg <= acc_r_next;
            end
            default: ;
        endcase
        if (state_reg == dtps_pkg::ST_OUT && out_free) begin
            if (pass_reg) begin
                m_data_reg <= {in_r_reg, in_l_reg};
            end else begin
                m_data_reg <= {sat(acc_r_reg), sat(acc_l_reg)};
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* design/dual_tap_delay_pitch_shifter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_tap_delay_pitch_shifter
// Two-tap crossfaded delay-line octave shifter for a stereo sample stream.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake          Contents
//  s_        in         s_tvalid/s_tready  stereo sample request
//  m_        out        m_tvalid/m_tready  shifted stereo sample
//  cfg_      in         cfg_we             register write, no read-back
//
// A sample is taken and written to the stores; then each of the two taps
// forms its split delay product, reads two store entries, interpolates and
// is weighted and summed, and the result is emitted. Pass-through skips the taps.
// After reset the stores are swept to zero; no request is accepted meanwhile.
// A two-entry queue takes requests while the back end works, and the output
// register holds a result while the next one is built.
// ----------------------------------------------------------------------------
module dual_tap_delay_pitch_shifter #(
    parameter int DELAY_DEPTH       = 65536,
    parameter int SAMPLE_BITS       = 24,
    parameter int WINDOW_TABLE_SIZE = 1024
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [23:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // in_left, in_right, zero padding
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_left, out_right, zero padding
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0] m_tdata
);

    localparam int DW = ((2*SAMPLE_BITS+7)/8)*8;

    dtps_pkg::dtps_cfg_t     cfg;
    logic                    clearing;
    logic                    q_valid, q_ready;
    logic [2*SAMPLE_BITS-1:0] q_data, m_data;

    dtps_front #(
        .DELAY_DEPTH (DELAY_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .s_data    (s_tdata[2*SAMPLE_BITS-1:0]),
        .clearing  (clearing),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_data    (q_data),
        .cfg       (cfg)
    );

    dtps_back #(
        .DELAY_DEPTH       (DELAY_DEPTH),
        .SAMPLE_BITS       (SAMPLE_BITS),
        .WINDOW_TABLE_SIZE (WINDOW_TABLE_SIZE)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_data   (q_data),
        .clearing (clearing),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_data   (m_data)
    );

    assign m_tdata = DW'(m_data);

`ifndef SYNTHESIS
    // No request enters while the stores are being cleared.
    assert property (@(posedge aclk) disable iff (!aresetn)
        clearing |-> !(s_tvalid && s_tready))
        else $error("request accepted during clearing sweep");

    // No result exists before the clearing sweep is over.
    assert property (@(posedge aclk) disable iff (!aresetn)
        clearing |-> !m_tvalid)
        else $error("result shown during clearing sweep");

    // The back end takes a queued request only when one is there.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (q_ready && !q_valid) |=> !$rose(m_tvalid))
        else $error("result without a queued request");
`endif

endmodule

/* sim/tb_dual_tap_delay_pitch_shifter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dual_tap_delay_pitch_shifter
// Self-checking bench for the two-tap delay-line octave shifter.
// Stereo requests go in through a stream port with random gaps. Each accepted
// request runs through a bit-exact model of the delay stores, the phase ramp,
// the cosine window and the saturating sum. Results leave under random
// back-pressure and are checked field by field, in order, against that model.
// Register settings change between phases, only while the block is idle.
// ----------------------------------------------------------------------------
module tb_dual_tap_delay_pitch_shifter;

    localparam int DEPTH     = 65536;
    localparam int TAB_SIZE  = 1024;
    localparam int SPAN_MAX  = (DEPTH - 2) * 256;
    localparam int RAND_ITEMS = 1420;

    typedef struct {
        logic signed [23:0] left;
        logic signed [23:0] right;
    } stereo_t;

    typedef struct {
        logic signed [23:0] left;
        logic signed [23:0] right;
        bit                 pinned;
        logic signed [23:0] want_left;
        logic signed [23:0] want_right;
    } drive_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = dtps_pkg::REG_OCTAVE;
    logic [23:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;

    // Typed expectation travelling with the current request.
    logic               pin_use = 1'b0;
    logic signed [23:0] pin_left = '0;
    logic signed [23:0] pin_right = '0;

    // Model state.
    logic signed [23:0] hist [2][DEPTH];
    int                 wr_ptr;
    logic [23:0]        phase;
    int                 shift_oct;
    logic [23:0]        step_reg;
    logic [23:0]        span_reg;
    int                 cos_tab [TAB_SIZE];

    stereo_t shifted_q[$];
    int      mismatch_count = 0;
    int      result_count = 0;
    int      accept_count = 0;
    bit      steady = 1'b0;
    int      stall_left = 0;

    dual_tap_delay_pitch_shifter DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #2 aclk = ~aclk;

    // Quarter-wave cosine by a Taylor series in Q30.
    function automatic longint taylor_cos(longint x);
        longint divs [6] = '{132, 90, 56, 30, 12, 2};
        longint x2;
        longint h;
        x2 = (x * x) / 64'sd1073741824;
        h  = 64'sd1073741824;
        for (int i = 0; i < 6; i++)
            h = 64'sd1073741824 - ((x2 * h) / 64'sd1073741824) / divs[i];
        return h;
    endfunction

    task automatic build_cos_tab();
        longint t, r, x, c, hp;
        int q;
        hp = 64'sd1686629713;
        for (int k = 0; k < TAB_SIZE; k++) begin
            t = longint'(k) <<< 22;
            q = int'((t >>> 30) & 3);
            r = t & 64'sd1073741823;
            x = (r * hp) >>> 30;
            case (q)
                0: c = taylor_cos(x);
                1: c = -taylor_cos(hp - x);
                2: c = -taylor_cos(x);
                default: c = taylor_cos(hp - x);
            endcase
            c = (c + 8192) / 16384;
            if (c > 65536) c = 65536;
            if (c < -65536) c = -65536;
            cos_tab[k] = int'(c);
        end
    endtask

    task automatic model_reset();
        for (int i = 0; i < DEPTH; i++) begin
            hist[0][i] = '0;
            hist[1][i] = '0;
        end
        wr_ptr    = 0;
        phase     = '0;
        shift_oct = 0;
        step_reg  = 24'd2796;
        span_reg  = '0;
        build_cos_tab();
    endtask

    function automatic void model_write_reg(logic [1:0] idx, logic [23:0] val);
        case (idx)
            dtps_pkg::REG_OCTAVE:
                shift_oct = val[2] ? int'(val[2:0]) - 8 : int'(val[2:0]);
            dtps_pkg::REG_PHASE_STEP: step_reg = val;
            dtps_pkg::REG_SWEEP_SPAN: span_reg = (val > SPAN_MAX) ? 24'(SPAN_MAX) : val;
            default: ;
        endcase
    endfunction

    // Raised-cosine weight, Q1.16, from the top ten phase bits.
    function automatic longint window_at(logic [23:0] ph);
        return longint'((65536 - cos_tab[ph[23:14]]) / 2);
    endfunction

    // Interpolated tap value, sample scaled by 256.
    function automatic longint tap_at(int ch, logic [23:0] ph, bit up);
        longint eff, dly, rp, y0, y1;
        int i0, i1, fr;
        eff = up ? (64'sd1 <<< 24) - longint'(ph) : longint'(ph);
        dly = (eff * longint'(span_reg)) >>> 24;
        rp  = longint'(wr_ptr) * 256 - dly;
        if (rp < 0) rp += longint'(DEPTH) * 256;
        i0 = int'((rp >>> 8) % DEPTH);
        fr = int'(rp & 255);
        i1 = (i0 + 1) % DEPTH;
        y0 = longint'(hist[ch][i0]);
        y1 = longint'(hist[ch][i1]);
        return y0 * 256 + longint'(fr) * (y1 - y0);
    endfunction

    function automatic logic signed [23:0] shift_channel(int ch, logic signed [23:0] x);
        logic [23:0] p2;
        bit up;
        longint s;
        p2 = phase + 24'h800000;
        up = shift_oct > 0;
        if (shift_oct == 0) return x;
        s = tap_at(ch, phase, up) * window_at(phase) + tap_at(ch, p2, up) * window_at(p2);
        s = s >>> 24;
        if (s > 8388607) s = 8388607;
        if (s < -8388608) s = -8388608;
        return 24'(s);
    endfunction

    function automatic stereo_t shift_sample(logic signed [23:0] l, logic signed [23:0] r);
        stereo_t o;
        hist[0][wr_ptr] = l;
        hist[1][wr_ptr] = r;
        o.left  = shift_channel(0, l);
        o.right = shift_channel(1, r);
        wr_ptr  = (wr_ptr + 1) % DEPTH;
        phase   = phase + step_reg;
        return o;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (steady || roll < 60) return 0;
        if (roll < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Accepted requests feed the model; pinned rows override its prediction.
    always @(posedge aclk) begin
        stereo_t p;
        if (aresetn && s_tvalid && s_tready) begin
            p = shift_sample(s_tdata[23:0], s_tdata[47:24]);
            if (pin_use) begin
                p.left  = pin_left;
                p.right = pin_right;
            end
            shifted_q.push_back(p);
            accept_count++;
        end
    end

    // Result side: random back-pressure and in-order checking.
    always @(posedge aclk) begin
        stereo_t w;
        if (aresetn && m_tvalid && m_tready) begin
            result_count++;
            if (shifted_q.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result %h", $realtime, m_tdata);
            end else begin
                w = shifted_q.pop_front();
                if (m_tdata[23:0] !== w.left) begin
                    mismatch_count++;
                    $display("%0t: out_left expected %0d got %0d", $realtime,
                             w.left, $signed(m_tdata[23:0]));
                end
                if (m_tdata[47:24] !== w.right) begin
                    mismatch_count++;
                    $display("%0t: out_right expected %0d got %0d", $realtime,
                             w.right, $signed(m_tdata[47:24]));
                end
            end
        end
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_tready <= 1'b1;
            stall_left <= pick_gap();
        end
    end

    task automatic send_sample(logic signed [23:0] l, logic signed [23:0] r, bit pin,
                               logic signed [23:0] wl, logic signed [23:0] wr);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid  <= 1'b1;
        s_tdata   <= {r, l};
        pin_use   <= pin;
        pin_left  <= wl;
        pin_right <= wr;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Register writes only once the block has drained.
    task automatic write_regs(logic [2:0] oct, logic [23:0] stp, logic [23:0] spn);
        s_tvalid <= 1'b0;
        pin_use  <= 1'b0;
        @(posedge aclk);
        wait (shifted_q.size() == 0);
        repeat (30) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= dtps_pkg::REG_OCTAVE;     cfg_wdata <= 24'(oct);
        @(posedge aclk); model_write_reg(dtps_pkg::REG_OCTAVE, 24'(oct));
        cfg_addr <= dtps_pkg::REG_PHASE_STEP; cfg_wdata <= stp;
        @(posedge aclk); model_write_reg(dtps_pkg::REG_PHASE_STEP, stp);
        cfg_addr <= dtps_pkg::REG_SWEEP_SPAN; cfg_wdata <= spn;
        @(posedge aclk); model_write_reg(dtps_pkg::REG_SWEEP_SPAN, spn);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic signed [23:0] rand_sample();
        int roll;
        roll = $urandom_range(99);
        if (roll < 8)  return 24'sh800000;
        if (roll < 16) return 24'sh7FFFFF;
        if (roll < 30) return 24'($signed($urandom_range(4000)) - 2000);
        return 24'($urandom);
    endfunction

    drive_row_t rows [$];
    logic [2:0]  ph_oct  [10] = '{3'b111, 3'd2, 3'b100, 3'd3, 3'd0, 3'd1, 3'b101,
                                  3'b110, 3'd3, 3'b100};
    initial begin
        drive_row_t row;
        logic [23:0] stp, spn;
        int per_phase;
        model_reset();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Pass-through after reset: the output equals the input.
        rows = '{
            '{24'sh800000, 24'sh7FFFFF, 1, 24'sh800000, 24'sh7FFFFF},
            '{24'sh7FFFFF, 24'sh800000, 1, 24'sh7FFFFF, 24'sh800000},
            '{24'sh000000, 24'shFFFFFF, 1, 24'sh000000, 24'shFFFFFF},
            '{24'shAAAAAA, 24'sh555555, 1, 24'shAAAAAA, 24'sh555555},
            '{24'sh555555, 24'shAAAAAA, 1, 24'sh555555, 24'shAAAAAA},
            '{24'sh000001, 24'sh000000, 1, 24'sh000001, 24'sh000000},
            '{24'shFFFFFF, 24'sh000001, 1, 24'shFFFFFF, 24'sh000001},
            '{24'sh7FFFFF, 24'sh7FFFFF, 0, '0, '0},
            '{24'sh7FFFFF, 24'sh7FFFFF, 0, '0, '0},
            '{24'sh800000, 24'sh800000, 0, '0, '0},
            '{24'sh800000, 24'sh800000, 0, '0, '0},
            '{24'sh123456, 24'shEDCBA9, 0, '0, '0},
            '{24'sh7FFFFF, 24'sh800000, 0, '0, '0},
            '{24'sh800000, 24'sh7FFFFF, 0, '0, '0},
            '{24'sh400000, 24'shC00000, 0, '0, '0},
            '{24'sh000000, 24'sh000000, 0, '0, '0}
        };
        for (int i = 0; i < rows.size(); i++) begin
            // Shift up, zero span: both taps read the sample just written.
            if (i == 7) write_regs(3'd1, 24'h400000, 24'd0);
            // Shift down with saturated span and a small phase step.
            if (i == 11) write_regs(3'b100, 24'd1, 24'hFFFFFF);
            row = rows[i];
            send_sample(row.left, row.right, row.pinned, row.want_left, row.want_right);
        end

        per_phase = RAND_ITEMS / 10;
        for (int ph = 0; ph < 10; ph++) begin
            case (ph % 4)
                0: stp = 24'hFFFFFF;
                1: stp = 24'd0;
                default: stp = 24'($urandom_range(200000, 500));
            endcase
            case (ph % 3)
                0: spn = 24'($urandom_range(per_phase * 256));
                1: spn = (ph == 4) ? 24'hFFFFFF : 24'($urandom_range(40 * 256));
                default: spn = 24'($urandom);
            endcase
            write_regs(ph_oct[ph], stp, spn);
            steady = (ph % 4 == 2);
            for (int n = 0; n < per_phase; n++) begin
                if (ph == 5 && n == per_phase / 2) begin
                    s_tvalid <= 1'b0;
                    @(posedge aclk);
                    wait (shifted_q.size() == 0);
                    @(posedge aclk);
                end
                send_sample(rand_sample(), rand_sample(), 0, '0, '0);
            end
        end
        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait (shifted_q.size() == 0);
        repeat (50) @(posedge aclk);

        $display("Covered %0d requests and %0d results over 13 register settings,",
                 accept_count, result_count);
        $display("including pass-through, both shift directions and span saturation.");
        if (mismatch_count == 0 && shifted_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog.
    initial begin
        #8000000;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
